### sv/tarl_pkg.sv
package tarl_pkg;

   // Field and limit widths
   localparam int AXES          = 3;
   localparam int VALUE_BITS    = 16;
   localparam int STEP_BITS     = VALUE_BITS + 1;
   localparam int LIMIT_BITS    = 15;
   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS = 16;

   // Internal arithmetic width: room for value, limit and a few carries
   localparam int CALC_BITS =
      ((VALUE_BITS > LIMIT_BITS) ? VALUE_BITS : (LIMIT_BITS + 1)) + 4;

   // Register indexes
   localparam logic [CSR_INDEX_BITS-1:0] CSR_MAX_VELOCITY     = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_MAX_ACCELERATION = 2'd1;

   typedef logic signed [VALUE_BITS-1:0] value_type;
   typedef logic signed [STEP_BITS-1:0]  step_type;
   typedef logic signed [CALC_BITS-1:0]  calc_type;
   typedef logic        [LIMIT_BITS-1:0] limit_type;

   // Saturation bounds in the wide arithmetic format
   localparam calc_type VALUE_MAX = calc_type'((64'sd1 <<< (VALUE_BITS - 1)) - 64'sd1);
   localparam calc_type VALUE_MIN = calc_type'(-(64'sd1 <<< (VALUE_BITS - 1)));

   typedef struct packed {
      value_type roll_in;
      value_type pitch_in;
      value_type yaw_in;
   } req_payload_type;

   typedef struct packed {
      value_type roll_out;
      value_type pitch_out;
      value_type yaw_out;
   } rsp_payload_type;

   function automatic calc_type widen_value(value_type v);
      return {{(CALC_BITS - VALUE_BITS){v[VALUE_BITS-1]}}, v};
   endfunction

   function automatic calc_type widen_step(step_type v);
      return {{(CALC_BITS - STEP_BITS){v[STEP_BITS-1]}}, v};
   endfunction

   function automatic calc_type widen_limit(limit_type v);
      return {{(CALC_BITS - LIMIT_BITS){1'b0}}, v};
   endfunction

endpackage

### sv/tarl_lane.sv
module tarl_lane (
   input  logic               clock,
   input  logic               reset,
   input  logic               advance,
   input  tarl_pkg::value_type cmd,
   input  tarl_pkg::limit_type max_velocity,
   input  tarl_pkg::limit_type max_acceleration,
   output tarl_pkg::value_type result
);
   import tarl_pkg::*;

   value_type prev_ff;
   value_type prev_in;
   step_type  step_ff;
   step_type  step_in;

   calc_type cmd_x;
   calc_type prev_x;
   calc_type pstep_x;
   calc_type mv_x;
   calc_type ma_x;
   calc_type hi;
   calc_type lo;
   calc_type limited;
   calc_type step;
   calc_type diff;
   calc_type diff_lim;
   calc_type step_lim;
   calc_type sum;
   calc_type sat;
   calc_type new_step;

   // Velocity clamp, then acceleration clamp, then saturation
   always_comb begin
      cmd_x   = widen_value(cmd);
      prev_x  = widen_value(prev_ff);
      pstep_x = widen_step(step_ff);
      mv_x    = widen_limit(max_velocity);
      ma_x    = widen_limit(max_acceleration);
      hi      = prev_x + mv_x;
      lo      = prev_x - mv_x;
      if (cmd_x > hi) begin
         limited = hi;
      end else if (cmd_x < lo) begin
         limited = lo;
      end else begin
         limited = cmd_x;
      end
      step = limited - prev_x;
      diff = step - pstep_x;
      if (diff > ma_x) begin
         diff_lim = ma_x;
      end else if (diff < -ma_x) begin
         diff_lim = -ma_x;
      end else begin
         diff_lim = diff;
      end
      step_lim = pstep_x + diff_lim;
      sum      = prev_x + step_lim;
      if (sum > VALUE_MAX) begin
         sat = VALUE_MAX;
      end else if (sum < VALUE_MIN) begin
         sat = VALUE_MIN;
      end else begin
         sat = sum;
      end
      new_step = sat - prev_x;
      prev_in  = sat[VALUE_BITS-1:0];
      step_in  = new_step[STEP_BITS-1:0];
   end

   assign result = prev_in;

   // Advance axis state on each accepted request
   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff <= '0;
         step_ff <= '0;
      end else if (advance) begin
         prev_ff <= prev_in;
         step_ff <= step_in;
      end
   end

endmodule

### sv/tarl_merge.sv
module tarl_merge (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     load,
   input  tarl_pkg::rsp_payload_type data,
   input  logic                     rsp_stall,
   output logic                     rsp_valid,
   output tarl_pkg::rsp_payload_type rsp_payload,
   output logic                     full
);
   import tarl_pkg::*;

   logic            out_valid_ff;
   logic            out_valid_in;
   rsp_payload_type out_data_ff;
   rsp_payload_type out_data_in;
   logic            skid_valid_ff;
   logic            skid_valid_in;
   rsp_payload_type skid_data_ff;
   rsp_payload_type skid_data_in;
   logic            take;

   assign take = out_valid_ff && !rsp_stall;

   // Refill output from skid first, else from the lanes; park in skid when blocked
   always_comb begin
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (!out_valid_ff || take) begin
         if (skid_valid_ff) begin
            out_valid_in  = 1'b1;
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end else begin
            out_valid_in = load;
            if (load) begin
               out_data_in = data;
            end
         end
      end else if (load) begin
         skid_valid_in = 1'b1;
         skid_data_in  = data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign rsp_valid   = out_valid_ff;
   assign rsp_payload = out_data_ff;
   assign full        = skid_valid_ff;

endmodule

### sv/three_axis_rate_accel_limiter.sv
// Three-axis slew-rate and acceleration limiter on signed Q8.8 values. Each request
// carries roll, pitch and yaw commands; three lanes each clamp their command to within
// max_velocity of the previous output, limit the change of step to max_acceleration,
// and saturate to 16 bits. One request is taken every clock cycle while req_stall
// is low; its result is held on the rsp_ channel in an output register backed by
// a one-entry skid register, so req_stall rises only when both are full. The per-axis
// add/compare chain that closes the combinational state loop sets this rate.
// Write max_velocity (index 0) and max_acceleration (index 1) only while idle;
// both reset to zero, which holds every output at zero.
module three_axis_rate_accel_limiter (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   output logic                                    req_stall,
   input  tarl_pkg::req_payload_type               req_payload,
   output logic                                    rsp_valid,
   input  logic                                    rsp_stall,
   output tarl_pkg::rsp_payload_type               rsp_payload,
   input  logic                                    csr_valid,
   output logic                                    csr_ready,
   input  logic [tarl_pkg::CSR_INDEX_BITS-1:0]     csr_index,
   input  logic [tarl_pkg::CSR_DATA_BITS-1:0]      csr_data
);
   import tarl_pkg::*;

   limit_type       max_velocity_ff;
   limit_type       max_acceleration_ff;
   logic            accept;
   logic            full;
   value_type       cmd_value [AXES];
   value_type       result_value [AXES];
   rsp_payload_type merged;

   assign csr_ready = 1'b1;
   assign accept    = req_valid && !req_stall;
   assign req_stall = full;

   // Write limit registers
   always_ff @(posedge clock) begin
      if (reset) begin
         max_velocity_ff     <= '0;
         max_acceleration_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_MAX_VELOCITY: begin
               max_velocity_ff <= csr_data[LIMIT_BITS-1:0];
            end
            CSR_MAX_ACCELERATION: begin
               max_acceleration_ff <= csr_data[LIMIT_BITS-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // Split request into axis lanes
   assign cmd_value[0] = req_payload.roll_in;
   assign cmd_value[1] = req_payload.pitch_in;
   assign cmd_value[2] = req_payload.yaw_in;

   for (genvar a = 0; a < AXES; a++) begin : g_lane
      tarl_lane u_lane (
         .clock            (clock),
         .reset            (reset),
         .advance          (accept),
         .cmd              (cmd_value[a]),
         .max_velocity     (max_velocity_ff),
         .max_acceleration (max_acceleration_ff),
         .result           (result_value[a])
      );
   end

   // Gather lane results into one response
   assign merged.roll_out  = result_value[0];
   assign merged.pitch_out = result_value[1];
   assign merged.yaw_out   = result_value[2];

   tarl_merge u_merge (
      .clock       (clock),
      .reset       (reset),
      .load        (accept),
      .data        (merged),
      .rsp_stall   (rsp_stall),
      .rsp_valid   (rsp_valid),
      .rsp_payload (rsp_payload),
      .full        (full)
   );

   // Skid holds data only behind a full output register
   a_stall_needs_output: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid)
      else $error("request stalled with empty output register");

   // Accepted request always yields a pending response
   a_accept_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid)
      else $error("accepted request produced no response");

   // Blocked output plus new request fills the skid
   a_blocked_fills_skid: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall && accept) |=> req_stall)
      else $error("request lost behind stalled response");

endmodule

### tb/three_axis_rate_accel_limiter_tb.sv
module three_axis_rate_accel_limiter_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import tarl_pkg::*;

   localparam int CLOCK_PERIOD  = 8;
   localparam int LIMIT_CYCLES  = 500000;
   localparam int PHASES        = 14;
   localparam int PHASE_ITEMS   = 50;
   localparam int HOLD_OFF_LEN  = 300;
   localparam int VALUE_HIGH    = (1 <<< (VALUE_BITS - 1)) - 1;
   localparam int VALUE_LOW     = -(1 <<< (VALUE_BITS - 1));
   localparam value_type CMD_HIGH = value_type'(VALUE_HIGH);
   localparam value_type CMD_LOW  = value_type'(VALUE_LOW);
   localparam logic [15:0] LIMIT_FULL = 16'h7FFF;

   // Indexes past the register list; writes there must leave the limits alone
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SPARE_LOW  = 2'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SPARE_HIGH = 2'd3;

   // Per-axis limiter prediction and in-order result checking
   class limiter_scoreboard;
      int vel_limit;
      int accel_limit;
      int last_out[AXES];
      int last_step[AXES];
      rsp_payload_type expected_rates[$];
      int unsigned errors;
      int unsigned checked;
      int unsigned saturated;

      function new();
         vel_limit   = 0;
         accel_limit = 0;
         errors      = 0;
         checked     = 0;
         saturated   = 0;
         foreach (last_out[a]) begin
            last_out[a]  = 0;
            last_step[a] = 0;
         end
      endfunction

      function int clip(int x, int lo, int hi);
         if (x > hi) return hi;
         if (x < lo) return lo;
         return x;
      endfunction

      // Apply a register write; only the low limit bits are kept
      function void write_limit(logic [CSR_INDEX_BITS-1:0] idx, logic [CSR_DATA_BITS-1:0] data);
         if (idx == CSR_MAX_VELOCITY)
            vel_limit = int'(data[LIMIT_BITS-1:0]);
         else if (idx == CSR_MAX_ACCELERATION)
            accel_limit = int'(data[LIMIT_BITS-1:0]);
      endfunction

      // Slew clamp, then step-change clamp, then saturate; advance axis state
      function value_type limit_axis(int axis, value_type cmd);
         int prev;
         int pstep;
         int step;
         int diff;
         int raw;
         int result;
         prev  = last_out[axis];
         pstep = last_step[axis];
         step  = clip(int'(cmd), prev - vel_limit, prev + vel_limit) - prev;
         diff  = step - pstep;
         if ((diff < 0 ? -diff : diff) > accel_limit)
            step = pstep + clip(diff, -accel_limit, accel_limit);
         raw    = prev + step;
         result = clip(raw, VALUE_LOW, VALUE_HIGH);
         if (result != raw)
            saturated++;
         last_step[axis] = result - prev;
         last_out[axis]  = result;
         return value_type'(result);
      endfunction

      function void note_command(req_payload_type cmd);
         rsp_payload_type rates;
         rates.roll_out  = limit_axis(0, cmd.roll_in);
         rates.pitch_out = limit_axis(1, cmd.pitch_in);
         rates.yaw_out   = limit_axis(2, cmd.yaw_in);
         expected_rates.push_back(rates);
      endfunction

      function void compare_rate(string name, value_type exp_v, value_type act_v);
         if (exp_v !== act_v) begin
            errors++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
         end
      endfunction

      function void check_output(rsp_payload_type rates);
         rsp_payload_type exp_rates;
         if (expected_rates.size() == 0) begin
            errors++;
            $display("%0t: unexpected result, expected none, actual %0d %0d %0d", $time,
                     rates.roll_out, rates.pitch_out, rates.yaw_out);
            return;
         end
         exp_rates = expected_rates.pop_front();
         checked++;
         compare_rate("roll_out", exp_rates.roll_out, rates.roll_out);
         compare_rate("pitch_out", exp_rates.pitch_out, rates.pitch_out);
         compare_rate("yaw_out", exp_rates.yaw_out, rates.yaw_out);
      endfunction

      function int pending();
         return expected_rates.size();
      endfunction
   endclass

   logic                        clock = 1'b0;
   logic                        reset = 1'b1;
   logic                        req_valid = 1'b0;
   logic                        req_stall;
   req_payload_type             req_payload = '0;
   logic                        rsp_valid;
   logic                        rsp_stall = 1'b0;
   rsp_payload_type             rsp_payload;
   logic                        csr_valid = 1'b0;
   logic                        csr_ready;
   logic [CSR_INDEX_BITS-1:0]   csr_index = CSR_MAX_VELOCITY;
   logic [CSR_DATA_BITS-1:0]    csr_data = '0;

   limiter_scoreboard sb;
   int unsigned cycle_count = 0;
   int unsigned limit_settings = 0;
   int unsigned hold_offs = 0;
   int          hold_off_cycles = 0;
   bit          stall_free = 1'b0;
   int          trajectory[AXES];

   three_axis_rate_accel_limiter uut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data)
   );

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   // Abort a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("%0t: timeout after %0d cycles", $time, cycle_count);
         $display("three_axis_rate_accel_limiter regression: fail");
         $finish;
      end
   end

   // Observe all handshakes at the clock edge
   always @(posedge clock) begin
      if (!reset && sb != null) begin
         if (csr_valid && csr_ready)
            sb.write_limit(csr_index, csr_data);
         if (req_valid && !req_stall)
            sb.note_command(req_payload);
         if (rsp_valid && !rsp_stall)
            sb.check_output(rsp_payload);
      end
   end

   // Mostly short gaps, now and then a long one
   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   // Receiver: random stalls, quiet stretches, and one long hold-off on request
   initial begin : receiver
      int n;
      wait (!reset);
      @(posedge clock);
      forever begin
         if (hold_off_cycles > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold_off_cycles) @(posedge clock);
            hold_off_cycles = 0;
            hold_offs++;
         end else if (stall_free) begin
            rsp_stall <= 1'b0;
            @(posedge clock);
         end else begin
            n = gap_len();
            if (n > 0) begin
               rsp_stall <= 1'b1;
               repeat (n) @(posedge clock);
            end
            rsp_stall <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clock);
         end
      end
   end

   // Offer one request and hold it until taken; idle afterwards if asked
   task automatic send_command(value_type roll, value_type pitch, value_type yaw, int gap);
      req_valid           <= 1'b1;
      req_payload.roll_in  <= roll;
      req_payload.pitch_in <= pitch;
      req_payload.yaw_in   <= yaw;
      do @(posedge clock); while (req_stall);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Drop valid and wait until every expected result is back
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
   endtask

   task automatic csr_write(logic [CSR_INDEX_BITS-1:0] idx, logic [CSR_DATA_BITS-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // Reprogram both limits while idle, sometimes poking a spare index first
   task automatic set_limits(logic [CSR_DATA_BITS-1:0] vel, logic [CSR_DATA_BITS-1:0] acc,
                             bit spare);
      drain();
      if (spare)
         csr_write(($urandom_range(0, 1) != 0) ? CSR_SPARE_LOW : CSR_SPARE_HIGH,
                   CSR_DATA_BITS'($urandom));
      csr_write(CSR_MAX_VELOCITY, vel);
      csr_write(CSR_MAX_ACCELERATION, acc);
      limit_settings++;
   endtask

   function automatic logic [CSR_DATA_BITS-1:0] pick_limit();
      case ($urandom_range(0, 5))
         0:       return '0;
         1:       return LIMIT_FULL;
         2:       return CSR_DATA_BITS'($urandom_range(0, 512));
         3:       return CSR_DATA_BITS'($urandom_range(0, 4096));
         default: return CSR_DATA_BITS'($urandom);
      endcase
   endfunction

   // Mostly smooth trajectories with jumps, extremes and raw noise mixed in
   function automatic value_type pick_command(int axis);
      int r;
      r = $urandom_range(0, 99);
      if (r < 45) begin
         trajectory[axis] = trajectory[axis] + int'($urandom_range(0, 4000)) - 2000;
         if (trajectory[axis] > VALUE_HIGH) trajectory[axis] = VALUE_HIGH;
         if (trajectory[axis] < VALUE_LOW) trajectory[axis] = VALUE_LOW;
         return value_type'(trajectory[axis]);
      end
      if (r < 55) begin
         trajectory[axis] = int'(value_type'($urandom));
         return value_type'(trajectory[axis]);
      end
      if (r < 75)
         return value_type'($urandom);
      if (r < 88) begin
         case ($urandom_range(0, 3))
            0:       return value_type'(VALUE_HIGH);
            1:       return value_type'(VALUE_LOW);
            2:       return '0;
            default: return '1;
         endcase
      end
      return value_type'(trajectory[axis]);
   endfunction

   function automatic int next_gap();
      return stall_free ? 0 : gap_len();
   endfunction

   initial begin : stimulus
      sb = new();
      foreach (trajectory[a]) trajectory[a] = 0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset limits are zero: every output stays at zero
      send_command(CMD_HIGH, CMD_LOW, 16'sd12345, next_gap());
      send_command(-16'sd1, 16'sd1, 16'sd0, next_gap());

      // Wide writes with the top bit set, plus a write to an unused index
      set_limits(16'hFFFF, 16'hFFFF, 1'b1);
      send_command(16'sd30000, -16'sd30000, 16'sd30000, next_gap());

      // Small acceleration against a large previous step: output saturates
      set_limits(LIMIT_FULL, 16'd100, 1'b0);
      send_command(CMD_HIGH, CMD_LOW, CMD_LOW, next_gap());
      send_command(CMD_LOW, CMD_HIGH, 16'sd0, next_gap());

      // Zero velocity: hold the output
      set_limits('0, LIMIT_FULL, 1'b0);
      send_command(16'sd100, -16'sd100, CMD_HIGH, next_gap());
      send_command(CMD_LOW, CMD_HIGH, -16'sd1, next_gap());

      // Build a step, then zero acceleration keeps it until saturation
      set_limits(LIMIT_FULL, LIMIT_FULL, 1'b0);
      send_command(-16'sd10000, 16'sd9000, -16'sd12000, next_gap());
      set_limits(16'd256, '0, 1'b0);
      repeat (4) send_command(16'sd0, 16'sd0, 16'sd0, next_gap());

      // Field extremes with full limits
      set_limits(LIMIT_FULL, LIMIT_FULL, 1'b1);
      send_command(CMD_HIGH, CMD_LOW, -16'sd1, next_gap());
      send_command(CMD_LOW, CMD_HIGH, 16'sd1, next_gap());
      send_command(16'sd0, -16'sd1, CMD_HIGH, next_gap());
      send_command(-16'sd21846, 16'sd21845, CMD_LOW, next_gap());

      // Random phases, each under its own limit setting
      for (int p = 0; p < PHASES; p++) begin
         if (p == 0)
            set_limits(LIMIT_FULL, '0, 1'b0);
         else if (p == 1)
            set_limits('0, '0, 1'b0);
         else
            set_limits(pick_limit(), pick_limit(), $urandom_range(0, 3) == 0);
         stall_free = (p % 4 == 3);
         if (p == 5) begin
            // Long receiver hold-off while requests keep coming back to back
            hold_off_cycles = HOLD_OFF_LEN;
            for (int i = 0; i < PHASE_ITEMS; i++)
               send_command(pick_command(0), pick_command(1), pick_command(2), 0);
         end else begin
            for (int i = 0; i < PHASE_ITEMS; i++)
               send_command(pick_command(0), pick_command(1), pick_command(2), next_gap());
         end
      end

      stall_free = 1'b0;
      drain();
      repeat (10) @(posedge clock);

      $display("checked %0d limited commands under %0d limit settings", sb.checked,
               limit_settings);
      $display("%0d axis outputs saturated, %0d long receiver hold-offs", sb.saturated,
               hold_offs);
      if (sb.pending() != 0)
         $display("%0t: %0d results never arrived", $time, sb.pending());
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("three_axis_rate_accel_limiter regression: pass");
      end else begin
         $display("three_axis_rate_accel_limiter regression: fail");
      end
      $finish;
   end

endmodule
